@@ hw/rtl/gpr_pkg.sv @@
package gpr_pkg;

  localparam int GLYPH_SIZE = 8;
  localparam int PIXELS     = GLYPH_SIZE * GLYPH_SIZE;
  localparam int POS_W      = $clog2(PIXELS);
  localparam int COL_W      = $clog2(GLYPH_SIZE);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 2'd3;

  localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [14:0] RST_ROW_PITCH     = 15'd2560;
  localparam logic [31:0] RST_FRAME_BASE    = 32'd0;

  typedef struct packed {
    logic [PIXELS-1:0] glyph_bits;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [31:0]        ink_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_color;
    logic        last_write;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic advance;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic vis;
    logic out_ready;
    logic last;
  } sts_t;

endpackage

@@ hw/rtl/gpr_ctrl.sv @@
module gpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gpr_pkg::sts_t sts_i,
  output gpr_pkg::cmd_t cmd_o
);

  gpr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      gpr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = gpr_pkg::ST_SETUP;
        end
      end
      gpr_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = gpr_pkg::ST_SCAN;
      end
      gpr_pkg::ST_SCAN: begin
        cmd_o.advance = !sts_i.vis || sts_i.out_ready;
        cmd_o.emit    = sts_i.vis && sts_i.out_ready;
        if (cmd_o.advance && sts_i.last) begin
          state_d = gpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gpr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/gpr_datapath.sv @@
module gpr_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gpr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gpr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  gpr_pkg::in_item_t                in_item_i,
  input  gpr_pkg::cmd_t                    cmd_i,
  output gpr_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output gpr_pkg::out_item_t               out_item_o
);

  logic [12:0] width_q, height_q;
  logic [14:0] pitch_q;
  logic [31:0] base_q;

  logic [gpr_pkg::PIXELS-1:0] glyph_q;
  logic [15:0]                ox_q, oy_q;
  logic [31:0]                ink_q;

  logic [gpr_pkg::PIXELS-1:0] rem_q;
  logic [gpr_pkg::POS_W-1:0]  pos_q;
  logic [31:0]                rowacc_q;

  logic                       out_valid_q;
  gpr_pkg::out_item_t         out_q;

  logic [16:0]                xs [gpr_pkg::GLYPH_SIZE];
  logic [16:0]                ys [gpr_pkg::GLYPH_SIZE];
  logic [gpr_pkg::GLYPH_SIZE-1:0] colv, rowv;
  logic [gpr_pkg::PIXELS-1:0] vis_mask;
  logic signed [29:0]         prod;
  logic [31:0]                rowbase;
  logic [31:0]                stride4;
  logic [gpr_pkg::COL_W-1:0]  col;
  logic [16:0]                x_cur;
  logic [31:0]                addr;
  logic [gpr_pkg::PIXELS-1:0] rem_next;
  logic                       out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gpr_pkg::RST_SCREEN_WIDTH;
      height_q <= gpr_pkg::RST_SCREEN_HEIGHT;
      pitch_q  <= gpr_pkg::RST_ROW_PITCH;
      base_q   <= gpr_pkg::RST_FRAME_BASE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gpr_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i[12:0];
        gpr_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i[12:0];
        gpr_pkg::CFG_ROW_PITCH:     pitch_q  <= cfg_wdata_i[14:0];
        gpr_pkg::CFG_FRAME_BASE:    base_q   <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < gpr_pkg::GLYPH_SIZE; c++) begin
      xs[c]   = {ox_q[15], ox_q} + 17'(c);
      colv[c] = !xs[c][16] && (xs[c][15:0] < {3'b000, width_q});
      ys[c]   = {oy_q[15], oy_q} + 17'(c);
      rowv[c] = !ys[c][16] && (ys[c][15:0] < {3'b000, height_q});
    end
    for (int r = 0; r < gpr_pkg::GLYPH_SIZE; r++) begin
      for (int c = 0; c < gpr_pkg::GLYPH_SIZE; c++) begin
        vis_mask[r*gpr_pkg::GLYPH_SIZE+c] =
          glyph_q[r*gpr_pkg::GLYPH_SIZE+c] & rowv[r] & colv[c];
      end
    end
  end

  assign prod    = 30'($signed(oy_q)) * 30'($signed({1'b0, pitch_q[14:2]}));
  assign rowbase = base_q + {prod, 2'b00};
  assign stride4 = {17'b0, pitch_q[14:2], 2'b00};

  assign col      = pos_q[gpr_pkg::COL_W-1:0];
  assign x_cur    = xs[col];
  assign addr     = rowacc_q + {{13{x_cur[16]}}, x_cur, 2'b00};
  assign rem_next = rem_q & ~({{(gpr_pkg::PIXELS-1){1'b0}}, 1'b1} << pos_q);

  assign out_ready = !out_valid_q || !out_stall_i;

  assign sts_o.vis       = rem_q[pos_q];
  assign sts_o.out_ready = out_ready;
  assign sts_o.last      = (pos_q == gpr_pkg::POS_W'(gpr_pkg::PIXELS - 1)) ||
                           (rem_next == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      glyph_q <= in_item_i.glyph_bits;
      ox_q    <= in_item_i.origin_x;
      oy_q    <= in_item_i.origin_y;
      ink_q   <= in_item_i.ink_color;
    end
    if (cmd_i.setup) begin
      rowacc_q <= rowbase;
    end else if (cmd_i.advance && (col == gpr_pkg::COL_W'(gpr_pkg::GLYPH_SIZE - 1))) begin
      rowacc_q <= rowacc_q + stride4;
    end
    if (cmd_i.emit) begin
      out_q.write_address <= addr;
      out_q.write_color   <= ink_q;
      out_q.last_write    <= (rem_next == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.setup) begin
        rem_q <= vis_mask;
        pos_q <= '0;
      end else if (cmd_i.advance) begin
        rem_q <= rem_next;
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hw/rtl/glyph_pixel_rasterizer.sv @@
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  gpr_pkg::in_item_t (glyph, origin, ink)
// out       output     out_valid_o/out_stall_i gpr_pkg::out_item_t (address, color, last)
// cfg       input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One glyph is loaded, then goes through a setup state and one scan step per bit position up
// to its last visible pixel.
// The scan walks up to 64 positions one per cycle; each visible pixel is one item out.
// An output stall holds the scan on the pending visible pixel.
// Reset restores the screen registers to 640x480, pitch 2560, base 0.
module glyph_pixel_rasterizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gpr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gpr_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gpr_pkg::out_item_t             out_item_o
);

  gpr_pkg::cmd_t cmd;
  gpr_pkg::sts_t sts;

  gpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gpr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ verif/glyph_pixel_rasterizer_tb.sv @@
module glyph_pixel_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 140;
  localparam int STUCK_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [gpr_pkg::CFG_IDX_W-1:0]  cfg_index_i = gpr_pkg::CFG_SCREEN_WIDTH;
  logic [gpr_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  gpr_pkg::in_item_t              in_item_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  gpr_pkg::out_item_t             out_item_o;

  // screen registers as the block should hold them
  logic [12:0] scr_w = gpr_pkg::RST_SCREEN_WIDTH;
  logic [12:0] scr_h = gpr_pkg::RST_SCREEN_HEIGHT;
  logic [14:0] pitch = gpr_pkg::RST_ROW_PITCH;
  logic [31:0] base  = gpr_pkg::RST_FRAME_BASE;

  gpr_pkg::out_item_t pixel_q[$];
  gpr_pkg::out_item_t exp_px;
  int unsigned fail_cnt = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_left = 0;
  bit          idle_en = 1'b1;

  glyph_pixel_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // expected pixel writes of one glyph, row-major scan
  function automatic void rasterize(gpr_pkg::in_item_t g);
    int        x;
    int        y;
    logic [31:0] word;
    gpr_pkg::out_item_t px;
    gpr_pkg::out_item_t prev;
    bit        have_prev;
    have_prev = 1'b0;
    prev = '0;
    for (int row = 0; row < gpr_pkg::GLYPH_SIZE; row++) begin
      for (int col = 0; col < gpr_pkg::GLYPH_SIZE; col++) begin
        if (!g.glyph_bits[row*gpr_pkg::GLYPH_SIZE+col]) continue;
        x = $signed(g.origin_x) + col;
        y = $signed(g.origin_y) + row;
        if (x < 0 || y < 0 || x >= int'(scr_w) || y >= int'(scr_h)) continue;
        word = 32'(y) * 32'(pitch >> 2) + 32'(x);
        px.write_address = base + (word << 2);
        px.write_color   = g.ink_color;
        px.last_write    = 1'b0;
        if (have_prev) pixel_q.push_back(prev);
        prev = px;
        have_prev = 1'b1;
      end
    end
    if (have_prev) begin
      prev.last_write = 1'b1;
      pixel_q.push_back(prev);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          gpr_pkg::CFG_SCREEN_WIDTH:  scr_w = cfg_wdata_i[12:0];
          gpr_pkg::CFG_SCREEN_HEIGHT: scr_h = cfg_wdata_i[12:0];
          gpr_pkg::CFG_ROW_PITCH:     pitch = cfg_wdata_i[14:0];
          gpr_pkg::CFG_FRAME_BASE:    base  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) rasterize(in_item_i);
      if (out_valid_o && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel write: write_address %h write_color %h last_write %b",
                 out_item_o.write_address, out_item_o.write_color, out_item_o.last_write);
          fail_cnt++;
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_item_o.write_address !== exp_px.write_address) begin
            $error("write_address: expected %h, got %h",
                   exp_px.write_address, out_item_o.write_address);
            fail_cnt++;
          end
          if (out_item_o.write_color !== exp_px.write_color) begin
            $error("write_color: expected %h, got %h",
                   exp_px.write_color, out_item_o.write_color);
            fail_cnt++;
          end
          if (out_item_o.last_write !== exp_px.last_write) begin
            $error("last_write: expected %b, got %b",
                   exp_px.last_write, out_item_o.last_write);
            fail_cnt++;
          end
        end
      end
      if (cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // output side: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < 9);
    end
  end

  function automatic gpr_pkg::in_item_t glyph(logic [63:0] bits, logic [15:0] ox,
                                              logic [15:0] oy, logic [31:0] ink);
    gpr_pkg::in_item_t g;
    g.glyph_bits = bits;
    g.origin_x   = ox;
    g.origin_y   = oy;
    g.ink_color  = ink;
    return g;
  endfunction

  function automatic logic [15:0] pick_origin(logic [12:0] lim);
    int v;
    if ($urandom_range(99) < 10) return 16'($urandom);
    v = int'($urandom_range(32'(lim) + 9)) - 8;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic gpr_pkg::in_item_t random_glyph();
    logic [63:0] bits;
    case ($urandom_range(3))
      0: bits = {$urandom, $urandom};
      1: bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: bits = {$urandom, $urandom} | {$urandom, $urandom};
      default: bits = 64'd1 << $urandom_range(63);
    endcase
    return glyph(bits, pick_origin(scr_w), pick_origin(scr_h), $urandom);
  endfunction

  task automatic send_glyph(input gpr_pkg::in_item_t g);
    while (idle_en && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= g;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // block may still scan a glyph that produces nothing
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_screen(input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] p, input logic [31:0] b);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= gpr_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_index_i <= gpr_pkg::CFG_SCREEN_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_index_i <= gpr_pkg::CFG_ROW_PITCH;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_index_i <= gpr_pkg::CFG_FRAME_BASE;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_directed_glyphs();
    send_glyph(glyph('1, 16'd0, 16'd0, 32'hFFFF_FFFF));
    send_glyph(glyph('0, 16'd0, 16'd0, 32'h1234_5678));
    send_glyph(glyph(64'd1, 16'h8000, 16'h8000, 32'hA5A5_A5A5));
    send_glyph(glyph(64'd1 << 63, 16'h7FFF, 16'h7FFF, 32'h5A5A_5A5A));
    send_glyph(glyph('1, -16'sd7, -16'sd7, 32'hDEAD_BEEF));
    send_glyph(glyph('1, 16'd636, 16'd476, 32'h0000_0001));
    send_glyph(glyph(64'h55AA_55AA_55AA_55AA, 16'd100, 16'd200, 32'h0));
    send_glyph(glyph(64'hAA55_AA55_AA55_AA55, 16'd632, 16'd472, 32'h8000_0000));
    send_glyph(glyph('1, 16'd640, 16'd0, 32'h1111_1111));
    drain();
  endtask

  task automatic test_clip_limits();
    set_screen(32'd1, 32'd1, 32'd2560, 32'd0);
    send_glyph(glyph('1, 16'd0, 16'd0, 32'h2222_2222));
    send_glyph(glyph('1, -16'sd3, -16'sd5, 32'h3333_3333));
    drain();
    set_screen(32'd0, 32'd480, 32'd2560, 32'd0);
    send_glyph(glyph('1, 16'd0, 16'd0, 32'h4444_4444));
    drain();
    set_screen(32'd640, 32'd0, 32'd2560, 32'd0);
    send_glyph(glyph('1, 16'd0, 16'd0, 32'h5555_5555));
    drain();
  endtask

  // pitch below four gives a zero word stride; base near the top wraps
  task automatic test_address_wrap();
    set_screen(32'd640, 32'd480, 32'd3, 32'hFFFF_FFF0);
    send_glyph(glyph('1, 16'd0, 16'd0, 32'h6666_6666));
    send_glyph(glyph({$urandom, $urandom}, 16'd2, 16'd5, 32'h7777_7777));
    drain();
    set_screen(32'd640, 32'd480, 32'd0, 32'hFFFF_FFFC);
    send_glyph(glyph('1, 16'd1, 16'd1, 32'h8888_8888));
    drain();
  endtask

  // all-ones size writes: upper data bits must be dropped by the width, height and pitch registers
  task automatic test_oversize_registers();
    set_screen(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    send_glyph(glyph('1, 16'd8184, 16'd8184, 32'h9999_9999));
    send_glyph(glyph('1, 16'd8190, 16'd8190, 32'hAAAA_AAAA));
    send_glyph(glyph('1, 16'h7FFF, 16'd0, 32'hBBBB_BBBB));
    drain();
    set_screen(32'd4096, 32'd4096, 32'd16384, 32'h8000_0000);
    send_glyph(glyph('1, 16'd4088, 16'd4088, 32'hCCCC_CCCC));
    send_glyph(glyph('1, 16'd4092, 16'd4093, 32'hDDDD_DDDD));
    drain();
  endtask

  task automatic test_backpressure();
    set_screen(32'(gpr_pkg::RST_SCREEN_WIDTH), 32'(gpr_pkg::RST_SCREEN_HEIGHT),
               32'(gpr_pkg::RST_ROW_PITCH), gpr_pkg::RST_FRAME_BASE);
    hold_left = HOLD_CYCLES;
    repeat (10)
      send_glyph(glyph('1, 16'($urandom_range(632)), 16'($urandom_range(472)), $urandom));
    drain();
  endtask

  task automatic test_random_glyphs();
    for (int ph = 0; ph < 7; ph++) begin
      idle_en = (ph != 3);
      case (ph)
        0: set_screen(32'(gpr_pkg::RST_SCREEN_WIDTH), 32'(gpr_pkg::RST_SCREEN_HEIGHT),
                      32'(gpr_pkg::RST_ROW_PITCH), gpr_pkg::RST_FRAME_BASE);
        1: set_screen($urandom_range(16, 1), $urandom_range(16, 1),
                      $urandom_range(64, 4), $urandom);
        5: set_screen($urandom_range(4096, 1), $urandom_range(4096, 1),
                      $urandom_range(3, 0), $urandom);
        default: set_screen($urandom_range(4096, 1), $urandom_range(4096, 1),
                            $urandom_range(16384, 4), $urandom);
      endcase
      repeat (40) send_glyph(random_glyph());
      drain();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_glyphs();
    test_clip_limits();
    test_address_wrap();
    test_oversize_registers();
    test_backpressure();
    test_random_glyphs();
    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
